// ===== hdl/itp_pkg.sv =====
// Shared types, character codes and digit decoding for the integer text parser.
`default_nettype none

package itp_pkg;

    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 88;
    localparam int BASE_W       = 6;
    localparam int VALUE_W      = 64;
    localparam int CONSUMED_W   = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'h3F;

    typedef enum logic [5:0] {
        PH_SKIP     = 6'b000001,
        PH_PREFIX   = 6'b000010,
        PH_ZERO     = 6'b000100,
        PH_HEXFIRST = 6'b001000,
        PH_DIGITS   = 6'b010000,
        PH_DONE     = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [BASE_W-1:0]    base;
        logic [VALUE_W-1:0]   acc;
        logic                 neg;
        logic                 seen;
    } parse_state_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_W-1:0]     value;
        logic                   negative;
        logic                   any_digits;
        logic [CONSUMED_W-1:0]  consumed;
    } parse_result_t;

    // Value of an alphanumeric character; NO_DIGIT for anything else.
    function automatic logic [BASE_W-1:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'hFF;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LC_A && c <= CH_LC_Z)
        begin
            d = c - CH_LC_A + 8'd10;
        end
        else if (c >= CH_UC_A && c <= CH_UC_Z)
        begin
            d = c - CH_UC_A + 8'd10;
        end
        return (d == 8'hFF) ? NO_DIGIT : d[BASE_W-1:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_text_parser_core.sv =====
// Top level of the streaming integer text parser.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata = ch[7:0]; tuser = first
//  m_*       out  m_tvalid/m_tready  tdata = value, negative, any_digits, consumed;
//                                    tuser = done_res
//  cfg_*     in   cfg_wr_en          cfg_wr_data = base_mode[5:0]
//
// Each request yields exactly one result, passed from the input register to the result register.
// A new request is taken every cycle while m_tready is high; the 64x6 multiply-add of the
// accumulator sits between the input register and the result register.
// Reset clears the parse state and sets the base register to ten.
// When the result register is held by m_tready low, the input register
// fills and s_tready drops until the result is taken.
`default_nettype none

module integer_text_parser_core
    import itp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [IN_TDATA_W-1:0]   s_tdata,   // [7:0] ch
    input  wire                     s_tuser,   // [0] first
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // [63:0] value, [64] negative, [65] any_digits, [81:66] consumed, [87:82] zero
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tuser,   // [0] done_res
    input  wire                     cfg_wr_en,
    input  wire  [BASE_W-1:0]       cfg_wr_data
);

    logic                   in_vld_reg;
    logic [7:0]             in_ch_reg;
    logic                   in_first_reg;
    logic                   out_vld_reg;
    parse_result_t          out_res_reg;
    parse_state_t           st_reg;
    parse_state_t           st_next;
    logic [COUNT_WIDTH-1:0] pos_reg;
    logic [COUNT_WIDTH-1:0] pos_next;
    logic [BASE_W-1:0]      base_mode_reg;
    parse_result_t          res_next;
    logic                   proc;

    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;

    itp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .st        (st_reg),
        .pos       (pos_reg),
        .base_mode (base_mode_reg),
        .ch        (in_ch_reg),
        .first     (in_first_reg),
        .st_next   (st_next),
        .pos_next  (pos_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            base_mode_reg <= BASE_DEC;
            st_reg.phase  <= PH_SKIP;
            st_reg.base   <= BASE_AUTO;
            st_reg.acc    <= '0;
            st_reg.neg    <= 1'b0;
            st_reg.seen   <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_mode_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_vld_reg <= 1'b0;
            end
            if (proc)
            begin
                out_vld_reg <= 1'b1;
                st_reg      <= st_next;
                pos_reg     <= pos_next;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg    <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (proc)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.done;
    assign m_tdata  = {6'b0, out_res_reg.consumed, out_res_reg.any_digits,
                       out_res_reg.negative, out_res_reg.value};

endmodule

`default_nettype wire

// ===== hdl/itp_step.sv =====
// Next-state and result logic for one character of the parse.
`default_nettype none

module itp_step
    import itp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  var parse_state_t          st,
    input  wire  [COUNT_WIDTH-1:0]    pos,
    input  wire  [BASE_W-1:0]         base_mode,
    input  wire  [7:0]                ch,
    input  wire                       first,
    output parse_state_t              st_next,
    output logic [COUNT_WIDTH-1:0]    pos_next,
    output parse_result_t             res
);

    parse_state_t           s;
    logic [COUNT_WIDTH-1:0] p;
    logic [COUNT_WIDTH-1:0] p_inc;
    logic [COUNT_WIDTH-1:0] fin_cnt;
    logic [31:0]            cnt_wide;
    logic [BASE_W-1:0]      dval;
    logic [BASE_W-1:0]      base_eff;
    logic                   pre;
    logic                   zer;
    logic                   go_digits;
    logic                   digit_ok;
    logic                   fin;

    assign dval = digit_value(ch);

    always_comb
    begin
        s = st;
        p = pos;
        // A new string restarts the parse and latches the base register.
        if (first)
        begin
            s.phase = PH_SKIP;
            s.base  = base_mode;
            s.acc   = '0;
            s.neg   = 1'b0;
            s.seen  = 1'b0;
            p       = '0;
        end
        p_inc     = (p == '1) ? p : p + 1'b1;
        st_next   = s;
        pos_next  = p;
        pre       = 1'b0;
        zer       = 1'b0;
        go_digits = 1'b0;
        digit_ok  = 1'b0;
        fin       = 1'b0;
        fin_cnt   = '0;
        base_eff  = s.base;

        unique case (s.phase)
            PH_SKIP:
            begin
                if (is_space(ch))
                begin
                    pos_next = p_inc;
                end
                else if (ch == CH_PLUS || ch == CH_MINUS)
                begin
                    st_next.neg   = (ch == CH_MINUS);
                    st_next.phase = PH_PREFIX;
                    pos_next      = p_inc;
                end
                else
                begin
                    pre = 1'b1;
                end
            end
            PH_PREFIX:   pre = 1'b1;
            PH_ZERO:     zer = 1'b1;
            PH_HEXFIRST:
            begin
                if (dval < BASE_HEX)
                begin
                    go_digits = 1'b1;
                end
                else
                begin
                    // Only the held zero counts: the number ends before the x.
                    fin     = 1'b1;
                    fin_cnt = (p != '0) ? p - 1'b1 : '0;
                end
            end
            PH_DIGITS:   go_digits = 1'b1;
            PH_DONE:     ;
            default:     ;
        endcase

        if (pre)
        begin
            if ((s.base == BASE_AUTO || s.base == BASE_HEX) && ch == CH_ZERO)
            begin
                st_next.acc   = '0;
                st_next.seen  = 1'b1;
                st_next.phase = PH_ZERO;
                pos_next      = p_inc;
            end
            else
            begin
                base_eff  = (s.base == BASE_AUTO) ? BASE_DEC : s.base;
                go_digits = 1'b1;
            end
        end

        if (zer)
        begin
            if (ch == CH_LC_X || ch == CH_UC_X)
            begin
                st_next.base  = BASE_HEX;
                st_next.phase = PH_HEXFIRST;
                pos_next      = p_inc;
            end
            else
            begin
                base_eff  = (s.base == BASE_AUTO) ? BASE_OCT : s.base;
                go_digits = 1'b1;
            end
        end

        if (go_digits)
        begin
            st_next.base  = base_eff;
            st_next.phase = PH_DIGITS;
            digit_ok = (base_eff >= BASE_MIN) && (base_eff <= BASE_MAX) && (dval < base_eff);
            if (digit_ok)
            begin
                st_next.acc  = s.acc * VALUE_W'(base_eff) + VALUE_W'(dval);
                st_next.seen = 1'b1;
                pos_next     = p_inc;
            end
            else
            begin
                fin     = 1'b1;
                fin_cnt = s.seen ? p : '0;
            end
        end

        cnt_wide = 32'(fin_cnt);
        res      = '0;
        if (fin)
        begin
            st_next.phase  = PH_DONE;
            res.done       = 1'b1;
            res.value      = s.neg ? (VALUE_W'(0) - s.acc) : s.acc;
            res.negative   = s.neg;
            res.any_digits = s.seen;
            res.consumed   = cnt_wide[CONSUMED_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/itp_checker.sv =====
// Port-level checks for the integer text parser, bound to the top level.
`default_nettype none

module itp_checker
    import itp_pkg::*;
(
    input wire                    clk,
    input wire                    rst_n,
    input wire                    s_tready,
    input wire                    m_tvalid,
    input wire                    m_tready,
    input wire [OUT_TDATA_W-1:0]  m_tdata,
    input wire                    m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An unfinished parse reports all fields as zero.
    a_not_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-final result carries data");

    // A finished parse without digits has nothing to report.
    a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && !m_tdata[65] |-> m_tdata[63:0] == '0 && m_tdata[81:66] == '0)
        else $error("value or count without digits");

    // Requests are only refused while a result waits downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind integer_text_parser_core itp_checker u_itp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming integer text parser core.
`default_nettype none

module testbench;
    import itp_pkg::*;

    // Mirrors the parser one request at a time and holds the results still owed by the core.
    class parse_scoreboard;
        logic [BASE_W-1:0]     base_reg;
        phase_t                phase;
        logic [BASE_W-1:0]     base_now;
        logic [VALUE_W-1:0]    acc;
        logic                  minus;
        logic                  seen;
        logic [CONSUMED_W-1:0] pos;
        parse_result_t         expected_parses[$];
        int                    errors;
        int                    checked;
        int                    accepted;

        function new();
            base_reg = BASE_DEC;
            restart_parse();
            base_now = BASE_AUTO;
            errors   = 0;
            checked  = 0;
            accepted = 0;
        endfunction

        function void restart_parse();
            phase    = PH_SKIP;
            base_now = base_reg;
            acc      = '0;
            minus    = 1'b0;
            seen     = 1'b0;
            pos      = '0;
        endfunction

        function void step_pos();
            if (pos != '1)
            begin
                pos++;
            end
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                   (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
        endfunction

        // Digit weight of c in base b, or -1 when c is not a digit of that base.
        function int digit_in(logic [7:0] c, logic [BASE_W-1:0] b);
            int d;
            if (b < BASE_MIN || b > BASE_MAX)
            begin
                return -1;
            end
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = int'(c) - int'(CH_ZERO);
            end
            else if (c >= CH_LC_A && c <= CH_LC_Z)
            begin
                d = int'(c) - int'(CH_LC_A) + 10;
            end
            else if (c >= CH_UC_A && c <= CH_UC_Z)
            begin
                d = int'(c) - int'(CH_UC_A) + 10;
            end
            else
            begin
                return -1;
            end
            return (d < int'(b)) ? d : -1;
        endfunction

        function parse_result_t close_parse(logic [CONSUMED_W-1:0] cnt);
            parse_result_t r;
            r            = '0;
            r.done       = 1'b1;
            r.value      = minus ? (64'd0 - acc) : acc;
            r.negative   = minus;
            r.any_digits = seen;
            r.consumed   = cnt;
            phase        = PH_DONE;
            return r;
        endfunction

        function parse_result_t predict_result(logic [7:0] c, logic start);
            parse_result_t r;
            int d;
            r = '0;
            if (start)
            begin
                restart_parse();
            end
            if (phase == PH_DONE)
            begin
                return r;
            end
            if (phase == PH_SKIP)
            begin
                if (is_blank(c))
                begin
                    step_pos();
                    return r;
                end
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    minus = (c == CH_MINUS);
                    step_pos();
                    phase = PH_PREFIX;
                    return r;
                end
                phase = PH_PREFIX;
            end
            if (phase == PH_PREFIX)
            begin
                if ((base_now == BASE_AUTO || base_now == BASE_HEX) && c == CH_ZERO)
                begin
                    acc  = '0;
                    seen = 1'b1;
                    step_pos();
                    phase = PH_ZERO;
                    return r;
                end
                if (base_now == BASE_AUTO)
                begin
                    base_now = BASE_DEC;
                end
                phase = PH_DIGITS;
            end
            if (phase == PH_ZERO)
            begin
                if (c == CH_LC_X || c == CH_UC_X)
                begin
                    base_now = BASE_HEX;
                    step_pos();
                    phase = PH_HEXFIRST;
                    return r;
                end
                if (base_now == BASE_AUTO)
                begin
                    base_now = BASE_OCT;
                end
                phase = PH_DIGITS;
            end
            if (phase == PH_HEXFIRST)
            begin
                // Only the held zero is the number, so the count stops short of the x.
                if (digit_in(c, BASE_HEX) < 0)
                begin
                    return close_parse((pos != 0) ? pos - 1'b1 : '0);
                end
                phase = PH_DIGITS;
            end
            d = digit_in(c, base_now);
            if (d >= 0)
            begin
                acc  = acc * 64'(base_now) + 64'(d);
                seen = 1'b1;
                step_pos();
                return r;
            end
            return close_parse(seen ? pos : '0);
        endfunction

        function void note_request(logic [7:0] c, logic start);
            expected_parses.push_back(predict_result(c, start));
            accepted++;
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic done_flag);
            parse_result_t e;
            if (expected_parses.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = expected_parses.pop_front();
            checked++;
            compare_field("done_res", 64'(e.done), 64'(done_flag));
            compare_field("value", e.value, data[63:0]);
            compare_field("negative", 64'(e.negative), 64'(data[64]));
            compare_field("any_digits", 64'(e.any_digits), 64'(data[65]));
            compare_field("consumed", 64'(e.consumed), 64'(data[81:66]));
            compare_field("padding", 64'd0, 64'(data[87:82]));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    cfg_wr_en;
    logic [BASE_W-1:0]       cfg_wr_data;

    parse_scoreboard sb = new();

    int sender_pct;
    int receiver_pct;
    int hold_cycles;
    int random_chars;
    int base_settings;
    logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT};

    integer_text_parser_core #(.COUNT_WIDTH(16)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Results are checked at the edge that takes them.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // Output side: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_pct);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(input logic [7:0] c, input logic start);
        @(negedge clk);
        while ($urandom_range(99) < sender_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(c, start);
    endtask

    task automatic send_string(input string txt, input bit with_first);
        for (int i = 0; i < txt.len(); i++)
        begin
            send_request(txt[i], with_first && (i == 0));
        end
    endtask

    // Drops valid and lets every owed result drain.
    task automatic finish_phase();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_parses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        sb.base_reg = b;
        base_settings++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
        begin
            return CH_ZERO + 8'(v);
        end
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
    endfunction

    // One string: mostly a well-formed number in the current base, sometimes raw noise.
    task automatic send_random_text(output int live);
        logic [7:0] txt[$];
        int b;
        int eff;
        int n;
        int v;
        live = 0;
        b = sb.base_reg;
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_request(8'($urandom), 1'($urandom_range(1)));
            live = n;
            return;
        end
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(1, 3)) txt.push_back(blanks[$urandom_range(5)]);
        end
        v = $urandom_range(3);
        if (v == 0)
        begin
            txt.push_back(CH_PLUS);
        end
        else if (v == 1)
        begin
            txt.push_back(CH_MINUS);
        end
        eff = b;
        if (b == BASE_AUTO || b == BASE_HEX)
        begin
            v = $urandom_range(3);
            if (v == 0)
            begin
                txt.push_back(CH_ZERO);
                txt.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
                eff = BASE_HEX;
            end
            else if (b == BASE_AUTO && v == 1)
            begin
                txt.push_back(CH_ZERO);
                eff = BASE_OCT;
            end
            else if (b == BASE_AUTO)
            begin
                txt.push_back(digit_char($urandom_range(1, 9)));
                eff = BASE_DEC;
            end
        end
        // With an invalid base the digits are still offered; none is taken.
        if (eff < BASE_MIN || eff > BASE_MAX)
        begin
            eff = BASE_DEC;
        end
        n = ($urandom_range(4) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
        repeat (n) txt.push_back(digit_char($urandom_range(eff - 1)));
        txt.push_back($urandom_range(1) ? 8'($urandom) : (n[0] ? 8'h00 : 8'h2C));
        repeat ($urandom_range(2)) txt.push_back(8'($urandom));
        live = txt.size();
        foreach (txt[i])
        begin
            send_request(txt[i], i == 0);
        end
    endtask

    initial
    begin
        logic [BASE_W-1:0] phase_bases[8];
        int p;
        int phase_chars;
        int live;
        bit pressured;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        sender_pct    = 0;
        receiver_pct  = 0;
        hold_cycles   = 0;
        random_chars  = 0;
        base_settings = 0;
        pressured     = 1'b0;
        phase_bases   = '{BASE_AUTO, BASE_HEX, BASE_DEC, BASE_MIN, BASE_MAX, BASE_OCT,
                          6'd1, 6'($urandom_range(3, 35))};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight after reset no base has been latched, so detection is automatic.
        send_request(CH_TAB, 1'b0);
        send_request(CH_VT, 1'b0);
        send_string("-0xF", 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(CH_UC_A, 1'b0);
        // Reset base of ten: the remaining blanks, a plus sign, a leading zero, NUL ends it.
        send_request(CH_SPACE, 1'b1);
        send_request(CH_LF, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(CH_FF, 1'b0);
        send_string("+017", 1'b0);
        send_request(8'h00, 1'b0);
        finish_phase();
        write_base(BASE_AUTO);
        send_string("0Xg", 1'b1);
        send_string("078", 1'b1);
        finish_phase();
        write_base(6'd1);
        send_string("5", 1'b1);
        finish_phase();
        write_base(BASE_MAX);
        send_string("Zz!", 1'b1);

        // A long blank run ahead of a short number.
        send_request(CH_SPACE, 1'b1);
        repeat (40) send_request(CH_SPACE, 1'b0);
        send_string("7.", 1'b0);
        finish_phase();

        p = 0;
        while (random_chars < 650)
        begin
            write_base(phase_bases[p % 8]);
            case (p % 4)
                0:
                begin
                    sender_pct   = 0;
                    receiver_pct = 0;
                end
                1:
                begin
                    sender_pct   = 56;
                    receiver_pct = 0;
                end
                2:
                begin
                    sender_pct   = 0;
                    receiver_pct = 56;
                end
                default:
                begin
                    sender_pct   = 20;
                    receiver_pct = 20;
                end
            endcase
            phase_chars = 0;
            while (phase_chars < 80)
            begin
                send_random_text(live);
                phase_chars += live;
                // Hold the output off while requests keep coming, so the core backs up.
                if (p == 4 && !pressured && phase_chars > 30)
                begin
                    hold_cycles = 48;
                    pressured   = 1'b1;
                end
            end
            random_chars += phase_chars;
            finish_phase();
            p++;
        end

        $display("Run covered %0d requests across %0d base settings and %0d random phases,",
                 sb.accepted, base_settings, p);
        $display("with a long blank run and a long output hold-off; %0d results checked.",
                 sb.checked);
        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
